// File: design/rrfe_pkg.sv
// Shared constants, codes and types for the receive ring frame extractor.
package rrfe_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;

  localparam logic [7:0] EMPTY_BYTE     = 8'h2A;
  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h75;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
  localparam int unsigned MIN_HELD      = 4;
  localparam logic [6:0] FRAME_CAP      = 7'd64;
  localparam logic [6:0] MAX_FRAME_RST  = 7'd64;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FRAME = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RB   = 7'b0000010,
    ST_NOFR = 7'b0000100,
    ST_F0   = 7'b0001000,
    ST_F1   = 7'b0010000,
    ST_F3   = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

endpackage

// File: design/rrfe_ring.sv
// Ring byte store: one write port, one registered read port.
module rrfe_ring #(
  parameter int unsigned DEPTH = rrfe_pkg::RING_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/rx_ring_frame_extractor_unit.sv
// Top level: receive ring buffer with frame sync and extraction sequencer.
//
//  port group | dir | handshake          | payload
//  -----------+-----+--------------------+-------------------------------------------
//  in_        | in  | in_valid/in_stall  | in_kind, in_rx_byte
//  out_       | out | out_valid/out_stall| out_byte, out_status, out_last, out_occupancy
//  cfg_       | in  | cfg_we             | cfg_max_frame
//
// Push and flush complete in idle. A byte read passes ST_RB, an empty or short ring
// read ST_NOFR, as does a frame read that drops sync bytes or rejects the length. An
// extracted frame reads its header through the single ring read port in ST_F0, ST_F1
// and ST_F3, then streams one byte per cycle while out_stall is low.
// The sequencer takes a new request only from idle; the output register lets one
// result wait under out_stall while the next request is taken. Reset (rst_n low,
// synchronous) clears the pointers and control state; ring contents stay as they are.
module rx_ring_frame_extractor_unit #(
  parameter int unsigned RING_DEPTH = rrfe_pkg::RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_status,
  output logic       out_last,
  output logic [7:0] out_occupancy,
  input  logic       cfg_we,
  input  logic [6:0] cfg_max_frame
);
  import rrfe_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (PW > 9) ? PW : 9;
  localparam logic [PW:0] DEPTH_W = (PW+1)'(RING_DEPTH);
  localparam logic [PW-1:0] FULL_CNT = PW'(RING_DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [PW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [6:0]    maxf_r, maxf_nxt;
  logic [5:0]    len_r, len_nxt, idx_r, idx_nxt;
  logic [PW-1:0] occf_r, occf_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_status_r, out_last_r;
  logic [7:0]    out_occ_r;

  logic [PW:0]   diff;
  logic [PW-1:0] held;
  logic [PW-1:0] rd_addr;
  logic [7:0]    mem_q;
  logic          wr_en;
  logic          out_free;
  logic          load;
  logic [7:0]    ld_byte;
  logic          ld_status, ld_last;
  logic [PW-1:0] ld_occ;
  logic [8:0]    len_c;
  logic [6:0]    lim;
  logic          len_ok;
  logic          emit_last;

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [PW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, p} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [7:0] occ8(input logic [PW-1:0] c);
    logic [CW-1:0] e;
    e = CW'(c);
    return e[7:0];
  endfunction

  rrfe_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  always_comb begin
    diff = {1'b0, wp_r} - {1'b0, rp_r};
    if (wp_r < rp_r) begin
      diff = diff + DEPTH_W;
    end
    held = diff[PW-1:0];
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign len_c     = {1'b0, mem_q} + FRAME_OVERHEAD;
  assign lim       = (maxf_r > FRAME_CAP) ? FRAME_CAP : maxf_r;
  assign len_ok    = (CW'(len_c) <= CW'(held)) && (len_c < {2'b00, lim});
  assign emit_last = (idx_r == (len_r - 6'd1));

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    occf_nxt  = occf_r;
    maxf_nxt  = cfg_we ? cfg_max_frame : maxf_r;
    rd_addr   = rp_r;
    wr_en     = 1'b0;
    load      = 1'b0;
    ld_byte   = EMPTY_BYTE;
    ld_status = 1'b1;
    ld_last   = 1'b1;
    ld_occ    = held;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_PUSH: begin
              // full ring drops the byte
              if (held != FULL_CNT) begin
                wr_en  = 1'b1;
                wp_nxt = ptr_add(wp_r, PW'(1));
              end
            end
            KIND_READ:  state_nxt = (held == '0) ? ST_NOFR : ST_RB;
            KIND_FRAME: state_nxt = (CW'(held) > CW'(MIN_HELD)) ? ST_F0 : ST_NOFR;
            KIND_FLUSH: begin
              rp_nxt = '0;
              wp_nxt = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RB: begin
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = mem_q;
          ld_status = 1'b0;
          ld_occ    = held - PW'(1);
          rp_nxt    = ptr_add(rp_r, PW'(1));
          state_nxt = ST_IDLE;
        end
      end
      ST_NOFR: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_F0: begin
        if (mem_q != SYNC_FIRST) begin
          rp_nxt    = ptr_add(rp_r, PW'(1));
          state_nxt = ST_NOFR;
        end else begin
          rd_addr   = ptr_add(rp_r, PW'(1));
          state_nxt = ST_F1;
        end
      end
      ST_F1: begin
        if (mem_q != SYNC_SECOND) begin
          rp_nxt    = ptr_add(rp_r, PW'(2));
          state_nxt = ST_NOFR;
        end else begin
          rd_addr   = ptr_add(rp_r, PW'(3));
          state_nxt = ST_F3;
        end
      end
      ST_F3: begin
        if (len_ok) begin
          len_nxt   = len_c[5:0];
          occf_nxt  = held - PW'(len_c);
          idx_nxt   = '0;
          rd_addr   = rp_r;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_NOFR;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = mem_q;
          ld_status = 1'b0;
          ld_last   = emit_last;
          ld_occ    = occf_r;
          if (emit_last) begin
            rp_nxt    = ptr_add(rp_r, PW'(len_r));
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 6'd1;
            // fetch the next byte so the stream keeps one per cycle while out_stall is low
            rd_addr = ptr_add(rp_r, PW'(idx_r + 6'd1));
          end
        end else begin
          rd_addr = ptr_add(rp_r, PW'(idx_r));
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      maxf_r      <= MAX_FRAME_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      maxf_r      <= maxf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    occf_r <= occf_nxt;
    if (load) begin
      out_byte_r   <= ld_byte;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
      out_occ_r    <= occ8(ld_occ);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occ_r;

endmodule

// File: design/rrfe_checker.sv
// Port-level checks for the receive ring frame extractor, bound to the top level.
module rrfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_status,
  input logic       out_last,
  input logic [7:0] out_occupancy
);
  import rrfe_pkg::*;

  // nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a no-byte result always carries the filler byte and closes its request
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_byte == EMPTY_BYTE) && out_last)
    else $error("empty result malformed");

  // within a frame the following byte is good data with the same occupancy
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      !out_valid || (!out_status && (out_occupancy == $past(out_occupancy))))
    else $error("frame stream broken");

  // no new request taken while a frame is still streaming
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("request taken mid-frame");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind rx_ring_frame_extractor_unit rrfe_checker u_rrfe_checker (.*);
